[rtl/core/ttse_pkg.sv]
// Shared constants, types and helpers for the text terminal screen engine.
`default_nettype none

package ttse_pkg;

  // Screen geometry
  localparam int ROWS   = 10;
  localparam int COLS   = 10;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);

  // Field widths
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;

  // Depth of the command queue between the parser and the executor
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Stream bytes with a meaning of their own
  localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;  // '^'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;  // 'c'
  localparam logic [CHAR_W-1:0] CH_H     = 8'h68;  // 'h'
  localparam logic [CHAR_W-1:0] CH_B     = 8'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;  // 'd'
  localparam logic [CHAR_W-1:0] CH_U     = 8'h75;  // 'u'
  localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;  // 'l'
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72;  // 'r'
  localparam logic [CHAR_W-1:0] CH_E     = 8'h65;  // 'e'
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;  // 'i'
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;  // 'o'

  // Commands passed from the parser to the executor
  typedef enum logic [3:0] {
    OP_NOP,
    OP_READ,
    OP_PUT,
    OP_CLEAR,
    OP_HOME,
    OP_COL0,
    OP_DOWN,
    OP_UP,
    OP_LEFT,
    OP_RIGHT,
    OP_ERASE,
    OP_INS_ON,
    OP_INS_OFF,
    OP_GOTO
  } op_code_t;

  typedef struct packed {
    op_code_t          code;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } op_t;

  // Linear cell address of a row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    int lin;
    lin = int'(row) * COLS + int'(col);
    return ADDR_W'(lin);
  endfunction

endpackage

`default_nettype wire

[rtl/core/text_terminal_screen_engine_unit.sv]
// Cursor, mode, clear, erase and overwrite commands complete as soon as they are taken
// from the queue; a cell read passes through the READ state, and an inserted character
// first shifts the row right cell by cell through the one write port and one read port
// of the cell RAM. Items are executed one at a time; a four-deep command queue keeps
// taking items meanwhile. On reset, per-cell flags blank the whole screen at once, so
// there is no clearing pass.
`default_nettype none

module text_terminal_screen_engine_unit
  import ttse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              func,
  input  wire logic [CHAR_W-1:0] char_in,
  input  wire logic [ROW_W-1:0]  read_row,
  input  wire logic [COL_W-1:0]  read_col,
  output logic                   empty,
  input  wire logic              pop,
  output logic [CHAR_W-1:0]      cell_char,
  output logic [ROW_W-1:0]       cursor_row,
  output logic [COL_W-1:0]       cursor_col,
  output logic                   insert_on
);

  op_t  fq_wdata, fq_rdata;
  logic fq_wr, fq_full, fq_rd, fq_empty;

  // Parse the incoming stream
  ttse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .func     (func),
    .char_in  (char_in),
    .read_row (read_row),
    .read_col (read_col),
    .q_full   (fq_full),
    .q_push   (fq_wr),
    .q_data   (fq_wdata)
  );

  // Decouple parser and executor
  ttse_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (fq_wr),
    .wdata (fq_wdata),
    .full  (fq_full),
    .rd    (fq_rd),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  // Execute commands on the screen
  ttse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (fq_rdata),
    .q_empty    (fq_empty),
    .q_pop      (fq_rd),
    .empty      (empty),
    .pop        (pop),
    .cell_char  (cell_char),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .insert_on  (insert_on)
  );

endmodule

`default_nettype wire

[rtl/core/ttse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ttse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/ttse_front.sv]
// Front end: escape parser that turns accepted items into screen commands.
`default_nettype none

module ttse_front
  import ttse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              func,
  input  wire logic [CHAR_W-1:0] char_in,
  input  wire logic [ROW_W-1:0]  read_row,
  input  wire logic [COL_W-1:0]  read_col,
  input  wire logic              q_full,
  output logic                   q_push,
  output op_t                    q_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CARET,
    PH_DIGIT
  } phase_t;

  phase_t           phase, phase_next;
  logic [ROW_W-1:0] pending, pending_next;
  logic             is_digit;
  logic [3:0]       digit;
  logic             feed;

  assign full     = q_full;
  assign q_push   = push && !q_full;
  assign feed     = q_push && !func;
  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign digit    = 4'(char_in - CH_ZERO);

  // Classify the item and work out the next parser phase
  always_comb begin
    q_data.code  = OP_NOP;
    q_data.ch    = char_in;
    q_data.row   = read_row;
    q_data.col   = read_col;
    phase_next   = phase;
    pending_next = pending;
    if (func) begin
      if ((int'(read_row) < ROWS) && (int'(read_col) < COLS)) begin
        q_data.code = OP_READ;
      end
    end else begin
      unique case (phase)
        PH_CARET: begin
          if (is_digit) begin
            pending_next = ROW_W'(digit);
            phase_next   = PH_DIGIT;
          end else begin
            phase_next = PH_IDLE;
            unique case (char_in)
              CH_C:     q_data.code = OP_CLEAR;
              CH_H:     q_data.code = OP_HOME;
              CH_B:     q_data.code = OP_COL0;
              CH_D:     q_data.code = OP_DOWN;
              CH_U:     q_data.code = OP_UP;
              CH_L:     q_data.code = OP_LEFT;
              CH_R:     q_data.code = OP_RIGHT;
              CH_E:     q_data.code = OP_ERASE;
              CH_I:     q_data.code = OP_INS_ON;
              CH_O:     q_data.code = OP_INS_OFF;
              CH_CARET: q_data.code = OP_PUT;
              default:  q_data.code = OP_NOP;
            endcase
          end
        end
        PH_DIGIT: begin
          phase_next = PH_IDLE;
          if (is_digit) begin
            q_data.code = OP_GOTO;
            q_data.row  = (int'(pending) > ROWS - 1) ? ROW_W'(ROWS - 1) : pending;
            q_data.col  = (int'(digit) > COLS - 1) ? COL_W'(COLS - 1) : COL_W'(digit);
          end else if (char_in == CH_CARET) begin
            phase_next = PH_CARET;
          end else begin
            q_data.code = OP_PUT;
          end
        end
        default: begin
          if (char_in == CH_CARET) begin
            phase_next = PH_CARET;
          end else begin
            q_data.code = OP_PUT;
          end
        end
      endcase
    end
  end

  // Hold parser state; advance only on an accepted stream byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pending <= '0;
    end else if (feed) begin
      phase   <= phase_next;
      pending <= pending_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ttse_fifo.sv]
// Short command queue between the parser and the executor.
`default_nettype none

module ttse_fifo
  import ttse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire op_t  wdata,
  output logic      full,
  input  wire logic rd,
  output op_t       rdata,
  output logic      empty
);

  op_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr, do_rd;

  assign full  = (int'(count) == QDEPTH);
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  // Store entries; payload needs no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= QPTR_W'(int'(wr_ptr) + 1);
      end
      if (do_rd) begin
        rd_ptr <= QPTR_W'(int'(rd_ptr) + 1);
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/ttse_back.sv]
// Back end: executes screen commands against the cell RAM and holds the result.
`default_nettype none

module ttse_back
  import ttse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire op_t               q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output logic [CHAR_W-1:0]      cell_char,
  output logic [ROW_W-1:0]       cursor_row,
  output logic [COL_W-1:0]       cursor_col,
  output logic                   insert_on
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT
  } state_t;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

  state_t             state;
  logic [ROW_W-1:0]   cur_row, imm_row;
  logic [COL_W-1:0]   cur_col, imm_col, adv_col, k, k_prev;
  logic               ins, imm_ins;
  logic [CELLS-1:0]   cell_vld;
  logic               rd_vld;
  logic [CHAR_W-1:0]  put_ch;
  logic               res_valid;
  logic [CHAR_W-1:0]  res_cell;
  logic [ROW_W-1:0]   res_row;
  logic [COL_W-1:0]   res_col;
  logic               res_ins;
  logic               slot_free, start, put_direct, imm_done;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr, cur_addr;
  logic [CHAR_W-1:0]  ram_wdata, ram_rdata;

  assign empty      = !res_valid;
  assign cell_char  = res_cell;
  assign cursor_row = res_row;
  assign cursor_col = res_col;
  assign insert_on  = res_ins;

  assign slot_free  = !res_valid || pop;
  assign start      = (state == ST_IDLE) && !q_empty && slot_free;
  assign q_pop      = start;
  assign adv_col    = (cur_col < LAST_COL) ? cur_col + 1'b1 : cur_col;
  assign put_direct = !ins || (cur_col == LAST_COL);
  assign k_prev     = k - 1'b1;
  assign cur_addr   = cell_addr(cur_row, cur_col);

  // Flag a command that completes and loads its result in the start cycle
  assign imm_done   = start && (q_data.code != OP_READ) &&
                      !((q_data.code == OP_PUT) && !put_direct);

  // Cursor and mode after a command that completes in the start cycle
  always_comb begin
    imm_row = cur_row;
    imm_col = cur_col;
    imm_ins = ins;
    unique case (q_data.code)
      OP_HOME: begin
        imm_row = '0;
        imm_col = '0;
      end
      OP_COL0:    imm_col = '0;
      OP_DOWN:    imm_row = (cur_row < LAST_ROW) ? cur_row + 1'b1 : cur_row;
      OP_UP:      imm_row = (cur_row != '0) ? cur_row - 1'b1 : cur_row;
      OP_LEFT:    imm_col = (cur_col != '0) ? cur_col - 1'b1 : cur_col;
      OP_RIGHT:   imm_col = adv_col;
      OP_PUT:     imm_col = adv_col;
      OP_INS_ON:  imm_ins = 1'b1;
      OP_INS_OFF: imm_ins = 1'b0;
      OP_GOTO: begin
        imm_row = q_data.row;
        imm_col = q_data.col;
      end
      default: begin
        imm_row = cur_row;
      end
    endcase
  end

  // Drive the RAM ports from the current step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = put_ch;
    ram_raddr = cell_addr(q_data.row, q_data.col);
    unique case (state)
      ST_IDLE: begin
        ram_we    = start && (q_data.code == OP_PUT) && put_direct;
        ram_wdata = q_data.ch;
      end
      ST_SHIFT_RD: ram_raddr = cell_addr(cur_row, k_prev);
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(cur_row, k);
        ram_wdata = ram_rdata;
      end
      ST_PUT:  ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  ttse_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequence commands, hold cursor, cell flags and the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_row   <= '0;
      cur_col   <= '0;
      ins       <= 1'b0;
      cell_vld  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid && !imm_done) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            put_ch <= q_data.ch;
            if (q_data.code == OP_READ) begin
              rd_vld <= cell_vld[cell_addr(q_data.row, q_data.col)];
              state  <= ST_READ;
            end else if ((q_data.code == OP_PUT) && !put_direct) begin
              k     <= LAST_COL;
              state <= ST_SHIFT_RD;
            end else begin
              if (q_data.code == OP_PUT) begin
                cell_vld[cur_addr] <= 1'b1;
              end else if (q_data.code == OP_CLEAR) begin
                cell_vld <= '0;
              end else if (q_data.code == OP_ERASE) begin
                for (int c = 0; c < COLS; c++) begin
                  if (c >= int'(cur_col)) begin
                    cell_vld[cell_addr(cur_row, COL_W'(c))] <= 1'b0;
                  end
                end
              end
              cur_row   <= imm_row;
              cur_col   <= imm_col;
              ins       <= imm_ins;
              res_valid <= 1'b1;
              res_cell  <= '0;
              res_row   <= imm_row;
              res_col   <= imm_col;
              res_ins   <= imm_ins;
            end
          end
        end
        ST_READ: begin
          res_valid <= 1'b1;
          res_cell  <= rd_vld ? ram_rdata : '0;
          res_row   <= cur_row;
          res_col   <= cur_col;
          res_ins   <= ins;
          state     <= ST_IDLE;
        end
        ST_SHIFT_RD: begin
          rd_vld <= cell_vld[cell_addr(cur_row, k_prev)];
          state  <= ST_SHIFT_WR;
        end
        ST_SHIFT_WR: begin
          cell_vld[cell_addr(cur_row, k)] <= rd_vld;
          k <= k_prev;
          if (k_prev == cur_col) begin
            state <= ST_PUT;
          end else begin
            state <= ST_SHIFT_RD;
          end
        end
        ST_PUT: begin
          cell_vld[cur_addr] <= 1'b1;
          cur_col   <= adv_col;
          res_valid <= 1'b1;
          res_cell  <= '0;
          res_row   <= cur_row;
          res_col   <= adv_col;
          res_ins   <= ins;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
